// ===== hw/rtl/assert_macros.svh =====
// Assertion macros for the matcher RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS

// Property must hold at every clock edge outside reset.
`define WBSM_ASSERT(label, clk_sig, rst_sig, prop) \
  label: assert property (@(posedge clk_sig) disable iff (rst_sig) prop) \
    else $error("assertion failed: label");

// Expression must never be true outside reset.
`define WBSM_ASSERT_NEVER(label, clk_sig, rst_sig, expr) \
  label: assert property (@(posedge clk_sig) disable iff (rst_sig) !(expr)) \
    else $error("forbidden condition: label");

`else

`define WBSM_ASSERT(label, clk_sig, rst_sig, prop)
`define WBSM_ASSERT_NEVER(label, clk_sig, rst_sig, expr)

`endif

`endif

// ===== hw/rtl/wbsm_pkg.sv =====
// Types and constants for the wildcard byte signature matcher.
package wbsm_pkg;

  localparam int MAX_PATTERN_BYTES = 16;
  localparam int ADDRESS_BITS      = 48;
  localparam int IDX_BITS          = $clog2(MAX_PATTERN_BYTES);
  localparam int LEN_BITS          = 5;
  localparam int COUNT_BITS        = 32;
  localparam int CFG_DATA_BITS     = 64;
  localparam int CFG_INDEX_BITS    = 2;
  localparam int CARE_BITS         = 16;

  // Register indexes of the configuration port
  localparam logic [CFG_INDEX_BITS-1:0] REG_PATTERN_LOW  = 2'd0;
  localparam logic [CFG_INDEX_BITS-1:0] REG_PATTERN_HIGH = 2'd1;
  localparam logic [CFG_INDEX_BITS-1:0] REG_CARE_MASK    = 2'd2;
  localparam logic [CFG_INDEX_BITS-1:0] REG_PATTERN_LEN  = 2'd3;

  // Reset values of the configuration
  localparam logic [63:0]           RESET_PATTERN_LOW  = 64'h0000_3E4C_CCCD_4120;
  localparam logic [63:0]           RESET_PATTERN_HIGH = 64'h0;
  localparam logic [CARE_BITS-1:0]  RESET_CARE_MASK    = 16'h303F;
  localparam logic [IDX_BITS-1:0]   RESET_LEN_M1       = 4'd13;

  localparam logic [COUNT_BITS-1:0] COUNT_MAX = '1;

  typedef logic [7:0] byte_t;

  typedef struct packed {
    byte_t                   data_byte;
    logic [ADDRESS_BITS-1:0] byte_address;
    logic                    starts_new_run;
  } in_word_t;

  typedef struct packed {
    logic [ADDRESS_BITS-1:0] match_address;
    logic [COUNT_BITS-1:0]   match_number;
  } out_word_t;

  // Shift control broadcast to every cell
  typedef struct packed {
    logic advance;
    logic restart;
  } cell_ctl_t;

  // What one cell compares against
  typedef struct packed {
    byte_t pattern;
    logic  cared;
    logic  active;
  } cell_cmp_t;

  // Data handed from one cell to the next
  typedef struct packed {
    byte_t window_byte;
    logic  valid;
  } cell_link_t;

endpackage

// ===== hw/rtl/wbsm_cell.sv =====
// One window cell: holds a byte and its valid bit, compares against a pattern byte.
module wbsm_cell (
  input  logic                clk,
  input  logic                rst,
  input  wbsm_pkg::cell_ctl_t  ctl,
  input  wbsm_pkg::cell_link_t link_in,
  input  wbsm_pkg::cell_cmp_t  cmp,
  output wbsm_pkg::cell_link_t link_out,
  output logic                filled,
  output logic                byte_ok
);
  import wbsm_pkg::*;

  byte_t window_byte;
  logic  valid;

  // Take the neighbor's byte on every accepted word
  always_ff @(posedge clk) begin
    if (ctl.advance) begin
      window_byte <= link_in.window_byte;
    end
  end

  // Valid bits track how far the current run has filled the window
  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else if (ctl.advance) begin
      valid <= link_in.valid;
    end
  end

  // Drop the valid bit downstream when a new run starts
  assign link_out.window_byte = window_byte;
  assign link_out.valid       = valid & ~ctl.restart;

  // Held byte belongs to the current run
  assign filled = valid;

  // Cells outside the pattern or under a wildcard always agree
  assign byte_ok = ~(cmp.active & cmp.cared & (window_byte != cmp.pattern));

endmodule

// ===== hw/rtl/wildcard_byte_signature_matcher.sv =====
// Top level of the wildcard byte signature matcher.
// Usage:
//   The input channel (in_valid/in_ready/in_word) takes one scanned byte per
//   word with its address and a new-run flag; bytes of one run arrive in
//   ascending address order. Set starts_new_run on the first byte after a
//   gap so no match spans two runs.
//   The output channel (out_valid/out_ready/out_word) gives zero or one word
//   per input byte: the start address of the match and the number of earlier
//   matches, saturating at all ones.
//   The configuration port (cfg_we/cfg_index/cfg_data) writes the pattern,
//   care mask and length; write it only while the block is idle.
// Timing:
//   A row of 16 cells holds the window and shifts one byte per accepted word,
//   so one byte per cycle is accepted while in_ready is high. A match is
//   compared on the window shifted in by the edge that accepts its last
//   byte and registered into out_valid. If the receiver stalls, one match
//   waits in the output register and one byte in the compare stage;
//   in_ready drops only when that byte also matches.
// Reset: rst (synchronous) empties the window, clears the match count and
//   loads the default pattern.
module wildcard_byte_signature_matcher (
  input  logic                                   clk,
  input  logic                                   rst,
  input  logic                                   in_valid,
  output logic                                   in_ready,
  input  wbsm_pkg::in_word_t                      in_word,
  output logic                                   out_valid,
  input  logic                                   out_ready,
  output wbsm_pkg::out_word_t                     out_word,
  input  logic                                   cfg_we,
  input  logic [wbsm_pkg::CFG_INDEX_BITS-1:0]     cfg_index,
  input  logic [wbsm_pkg::CFG_DATA_BITS-1:0]      cfg_data
);
  import wbsm_pkg::*;
  `include "assert_macros.svh"

  // Configuration
  logic [MAX_PATTERN_BYTES-1:0][7:0] pattern;
  logic [CARE_BITS-1:0]              care_mask;
  logic [IDX_BITS-1:0]               len_m1;
  logic [LEN_BITS-1:0]               cfg_len;
  logic [IDX_BITS-1:0]               cfg_len_m1;

  // Compare stage and counter
  logic                    s1_valid;
  logic [ADDRESS_BITS-1:0] s1_address;
  logic                    s1_hit;
  logic [COUNT_BITS-1:0]   matches_found;
  logic                    accept;
  logic                    s1_emit;

  cell_ctl_t                            ctl;
  cell_link_t [MAX_PATTERN_BYTES:0]     link;
  cell_cmp_t  [MAX_PATTERN_BYTES-1:0]   cmp;
  logic       [MAX_PATTERN_BYTES-1:0]   byte_ok;
  logic       [MAX_PATTERN_BYTES-1:0]   cell_valid;

  // Clamp the length to 1..MAX_PATTERN_BYTES, stored as length minus one
  assign cfg_len = cfg_data[LEN_BITS-1:0];
  always_comb begin
    if (cfg_len == '0) begin
      cfg_len_m1 = '0;
    end else if (cfg_len > LEN_BITS'(MAX_PATTERN_BYTES)) begin
      cfg_len_m1 = IDX_BITS'(MAX_PATTERN_BYTES - 1);
    end else begin
      cfg_len_m1 = IDX_BITS'(cfg_len - LEN_BITS'(1));
    end
  end

  // Load configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      pattern[7:0]  <= RESET_PATTERN_LOW;
      pattern[15:8] <= RESET_PATTERN_HIGH;
      care_mask     <= RESET_CARE_MASK;
      len_m1        <= RESET_LEN_M1;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_PATTERN_LOW:  pattern[7:0]  <= cfg_data;
        REG_PATTERN_HIGH: pattern[15:8] <= cfg_data;
        REG_CARE_MASK:    care_mask     <= cfg_data[CARE_BITS-1:0];
        REG_PATTERN_LEN:  len_m1        <= cfg_len_m1;
        default: ;
      endcase
    end
  end

  // Handshake: the compare stage frees up unless its match is blocked
  assign in_ready = ~s1_valid | ~s1_hit | ~out_valid | out_ready;
  assign accept   = in_valid & in_ready;
  assign s1_emit  = s1_valid & s1_hit & (~out_valid | out_ready);

  assign ctl.advance = accept;
  assign ctl.restart = in_word.starts_new_run;

  // Head of the chain: the incoming byte is always valid
  assign link[0].window_byte = in_word.data_byte;
  assign link[0].valid       = 1'b1;

  // Row of window cells; cell k holds the byte taken k words ago
  for (genvar k = 0; k < MAX_PATTERN_BYTES; k++) begin : g_cell
    logic [IDX_BITS-1:0] pat_idx;

    assign pat_idx       = len_m1 - IDX_BITS'(k);
    assign cmp[k].active = (IDX_BITS'(k) <= len_m1);
    assign cmp[k].pattern = pattern[pat_idx];
    assign cmp[k].cared  = (pat_idx == '0) | care_mask[pat_idx];

    wbsm_cell u_cell (
      .clk      (clk),
      .rst      (rst),
      .ctl      (ctl),
      .link_in  (link[k]),
      .cmp      (cmp[k]),
      .link_out (link[k+1]),
      .filled   (cell_valid[k]),
      .byte_ok  (byte_ok[k])
    );
  end

  // Match needs the window filled up to the pattern length in this run
  assign s1_hit = (&byte_ok) & cell_valid[len_m1];

  // Compare stage holds the address of the last byte shifted in
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else begin
      s1_valid <= accept | (s1_valid & ~in_ready);
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      s1_address <= in_word.byte_address;
    end
  end

  // Output register and saturating match counter
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid     <= 1'b0;
      matches_found <= '0;
    end else if (s1_emit) begin
      out_valid <= 1'b1;
      if (matches_found != COUNT_MAX) begin
        matches_found <= matches_found + COUNT_BITS'(1);
      end
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_emit) begin
      out_word.match_address <= s1_address - ADDRESS_BITS'(len_m1);
      out_word.match_number  <= matches_found;
    end
  end

  `WBSM_ASSERT(a_accept_fills_stage, clk, rst, accept |=> s1_valid)
  `WBSM_ASSERT_NEVER(a_blocked_match_ready, clk, rst,
                     s1_valid && s1_hit && out_valid && !out_ready && in_ready)
  `WBSM_ASSERT(a_count_monotonic, clk, rst,
               !$past(rst) |-> matches_found >= $past(matches_found))
  `WBSM_ASSERT(a_emit_counts, clk, rst,
               s1_emit && matches_found != COUNT_MAX |=>
                 matches_found == $past(matches_found) + COUNT_BITS'(1))

endmodule
